/* hw/rtl/swtq_pkg.sv */
// Shared widths and codes for the sorted wakeup timer queue.
// No dependencies; used by the channel interfaces, the slot store and the top level.
package swtq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TIME_BITS_DEF   = 32;
   localparam int MAX_RESULTS     = 16;
   localparam int RUN_BITS        = $clog2(MAX_RESULTS + 1);

   localparam int OP_BITS       = 2;
   localparam int ID_BITS       = 8;
   localparam int IN_TIME_BITS  = 32;
   localparam int STATUS_BITS   = 2;

   localparam logic [OP_BITS-1:0] OP_TICK      = 2'd0;
   localparam logic [OP_BITS-1:0] OP_SLEEP_ABS = 2'd1;
   localparam logic [OP_BITS-1:0] OP_SLEEP_REL = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_RELEASED = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_REACHED  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_REJECTED = 2'd2;

endpackage

/* hw/rtl/swtq_if.sv */
// Request and response channel interfaces (valid/ready, one transfer per handshake).
// Depends on swtq_pkg for field widths.
interface swtq_req_if
   import swtq_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [OP_BITS-1:0]      operation;
   logic [ID_BITS-1:0]      waiter_id;
   logic [IN_TIME_BITS-1:0] time_value;

   modport source (output valid, output operation, output waiter_id, output time_value,
                   input ready);
   modport sink   (input valid, input operation, input waiter_id, input time_value,
                   output ready);
endinterface

interface swtq_rsp_if
   import swtq_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [ID_BITS-1:0]     woken_id;
   logic [STATUS_BITS-1:0] status;
   logic                   last_of_run;

   modport source (output valid, output woken_id, output status, output last_of_run,
                   input ready);
   modport sink   (input valid, input woken_id, input status, input last_of_run,
                   output ready);
endinterface

/* hw/rtl/swtq_store.sv */
// Waiter slot memory: one write port, one read port with registered data.
// Depends on swtq_pkg for default sizes.
module swtq_store
   import swtq_pkg::*;
   #(
      parameter int  DEPTH      = QUEUE_DEPTH_DEF,
      parameter int  WIDTH      = TIME_BITS_DEF + ID_BITS,
      localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1
   )
   (
      input  logic                 clock,
      input  logic                 wr_en,
      input  logic [ADDR_BITS-1:0] wr_addr,
      input  logic [WIDTH-1:0]     wr_data,
      input  logic [ADDR_BITS-1:0] rd_addr,
      output logic [WIDTH-1:0]     rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/sorted_wakeup_timer_queue.sv */
// Sorted wakeup timer queue: tick counter plus deadline-ordered waiter ring.
// Tick: releases up to R <= 16 due waiters in deadline order; response stalls hold it back.
// Sleep: answered, or queued into an empty queue, from S_SLP_CHK; else each entry with a later
// deadline moves up one slot, one compare-and-move per cycle through the single slot memory port pair.
// One request at a time. Synchronous reset clears time and queue at once; no clearing pass.
// Depends on swtq_pkg, swtq_if and swtq_store.
module sorted_wakeup_timer_queue
   import swtq_pkg::*;
   #(
      parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
      parameter int TIME_BITS   = TIME_BITS_DEF
   )
   (
      input  logic       clock,
      input  logic       reset,
      swtq_req_if.sink   req_chan,
      swtq_rsp_if.source rsp_chan
   );

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int DW = TIME_BITS + ID_BITS;

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_SLP_CHK  = 5'b00010,
      S_INS_CMP  = 5'b00100,
      S_INS_PUT  = 5'b01000,
      S_TICK_CHK = 5'b10000
   } st_type;

   st_type                 state_ff, state_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [TIME_BITS-1:0]   dl_ff, dl_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [RUN_BITS-1:0]    n_ff, n_in;
   logic                   pend_ff, pend_in;
   logic [ID_BITS-1:0]     pend_id_ff, pend_id_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0]     woken_ff, woken_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic                   last_ff, last_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [DW-1:0]          wr_data;
   logic [AW-1:0]          rd_addr;
   logic [DW-1:0]          rd_data;
   logic [TIME_BITS-1:0]   rd_dl;
   logic [ID_BITS-1:0]     rd_id;

   logic                   req_xfer;
   logic                   out_free;
   logic                   due;
   logic [63:0]            tv_wide;
   logic [TIME_BITS-1:0]   tv;
   logic [TIME_BITS:0]     rel_sum;
   logic [CW:0]            tail_sum;
   logic [AW-1:0]          tail;

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
      return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
      return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
   endfunction

   swtq_store #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (DW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_dl = rd_data[DW-1:ID_BITS];
   assign rd_id = rd_data[ID_BITS-1:0];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign tv_wide  = {32'd0, req_chan.time_value};
   assign tv       = tv_wide[TIME_BITS-1:0];
   assign rel_sum  = {1'b0, time_ff} + {1'b0, tv};
   assign tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                     AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);

   assign due = (count_ff != '0) && (n_ff != RUN_BITS'(MAX_RESULTS)) && (rd_dl <= time_ff);

   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      dl_in        = dl_ff;
      id_in        = id_ff;
      n_in         = n_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      woken_in     = woken_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = {dl_ff, id_ff};
      rd_addr      = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               id_in = req_chan.waiter_id;
               priority if (req_chan.operation == OP_TICK) begin
                  if (time_ff != '1) begin
                     time_in = time_ff + 1'b1;
                  end
                  n_in     = '0;
                  pend_in  = 1'b0;
                  state_in = S_TICK_CHK;
               end else if (req_chan.operation == OP_SLEEP_ABS) begin
                  dl_in    = tv;
                  state_in = S_SLP_CHK;
               end else if (req_chan.operation == OP_SLEEP_REL) begin
                  dl_in    = rel_sum[TIME_BITS] ? '1 : rel_sum[TIME_BITS-1:0];
                  state_in = S_SLP_CHK;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_SLP_CHK: begin
            priority if (dl_ff <= time_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  woken_in     = id_ff;
                  status_in    = ST_REACHED;
                  last_in      = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (count_ff == CW'(QUEUE_DEPTH)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  woken_in     = id_ff;
                  status_in    = ST_REJECTED;
                  last_in      = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (count_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = tail;
               count_in = count_ff + 1'b1;
               state_in = S_IDLE;
            end else begin
               ptr_in   = tail;
               idx_in   = count_ff;
               rd_addr  = ring_dec(tail);
               state_in = S_INS_CMP;
            end
         end

         S_INS_CMP: begin
            if (rd_dl > dl_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               ptr_in  = ring_dec(ptr_ff);
               idx_in  = idx_ff - 1'b1;
               if (idx_ff == CW'(1)) begin
                  state_in = S_INS_PUT;
               end else begin
                  rd_addr = ring_dec(ring_dec(ptr_ff));
               end
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_IDLE;
            end
         end

         S_INS_PUT: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = S_IDLE;
         end

         S_TICK_CHK: begin
            if (pend_ff && out_free) begin
               rsp_valid_in = 1'b1;
               woken_in     = pend_id_ff;
               status_in    = ST_RELEASED;
               last_in      = !due;
            end
            if (!pend_ff || out_free) begin
               if (due) begin
                  head_in    = ring_inc(head_ff);
                  count_in   = count_ff - 1'b1;
                  n_in       = n_ff + 1'b1;
                  pend_in    = 1'b1;
                  pend_id_in = rd_id;
                  rd_addr    = ring_inc(head_ff);
               end else begin
                  pend_in  = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         n_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      idx_ff     <= idx_in;
      dl_ff      <= dl_in;
      id_ff      <= id_in;
      pend_id_ff <= pend_id_in;
      woken_ff   <= woken_in;
      status_ff  <= status_in;
      last_ff    <= last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.woken_id    = woken_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.last_of_run = last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("slot count above queue depth");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> time_ff >= $past(time_ff))
      else $error("tick count went backwards");

   a_no_pending_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> !pend_ff)
      else $error("request transfer while a release is still pending");

   a_insert_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_CMP) |-> (idx_ff != '0))
      else $error("insert scan ran past the queue head");
`endif

endmodule
